FILE: src/mlpd_pkg.sv
// Package for the multichannel length-prefix deframer.
// Beat types, opcodes, phase codes and default constants; no dependencies.
package mlpd_pkg;

	localparam int MLPD_NUM_CHANNELS   = 4;
	localparam int MLPD_QUEUE_DEPTH    = 2;
	localparam int LEN_BYTE_W          = 8;
	localparam logic [7:0]  START_BYTE = 8'h3C;   // '<'
	localparam logic [15:0] MAX_STORED_RESET = 16'd255;

	typedef struct packed {
		logic       mode;
		logic [1:0] channel;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  out_channel;
		logic [7:0]  payload_byte;
		logic [15:0] byte_offset;
		logic        byte_kept;
		logic        frame_last;
		logic [15:0] frame_length;
	} out_item_t;

	typedef enum logic {
		OP_DATA  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_START   = 2'd1,
		PH_LEN_LO  = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] channel;
		logic [7:0] data;
	} mid_entry_t;

	typedef struct packed {
		logic       push;
		mid_entry_t entry;
	} mid_wr_t;

endpackage

FILE: src/mlpd_fifo.sv
// Small register queue used between the front and back and on the result side.
// Generic width and depth; no package dependency.
module mlpd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok, pop_ok;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: src/mlpd_front.sv
// Front end: takes input beats, drops unknown channels, tags beats as data or clear.
// Depends on mlpd_pkg.
module mlpd_front import mlpd_pkg::*; #(
	parameter int NUM_CHANNELS = MLPD_NUM_CHANNELS
) (
	input  in_item_t item,
	input  logic     push,
	output logic     full,
	input  logic     mid_full,
	output mid_wr_t  mid_wr
);

	logic in_range;

	assign in_range = (int'(item.channel) < NUM_CHANNELS);
	assign full     = mid_full;

	always_comb begin
		mid_wr.push          = push && !mid_full && in_range;
		mid_wr.entry.op      = item.mode ? OP_CLEAR : OP_DATA;
		mid_wr.entry.channel = item.channel;
		mid_wr.entry.data    = item.rx_byte;
	end

endmodule

FILE: src/mlpd_back.sv
// Back end: per-channel deframer state, config register and result formatting.
// Depends on mlpd_pkg.
module mlpd_back import mlpd_pkg::*; #(
	parameter int NUM_CHANNELS = MLPD_NUM_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        mid_empty,
	input  mid_entry_t  mid_entry,
	output logic        mid_pop,
	input  logic        out_full,
	output logic        out_push,
	output out_item_t   out_entry
);

	localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	phase_t      phase_q [NUM_CHANNELS];
	logic [15:0] len_q   [NUM_CHANNELS];
	logic [15:0] rcvd_q  [NUM_CHANNELS];
	logic [15:0] max_q;

	logic [CH_IDX_W-1:0] idx;
	logic                go;
	phase_t              cur_phase, nxt_phase;
	logic [15:0]         cur_len, cur_rcvd, nxt_len, nxt_rcvd, full_len;
	logic [16:0]         off_inc;
	logic                last;

	assign idx       = CH_IDX_W'(mid_entry.channel);
	assign go        = !mid_empty && !out_full;
	assign mid_pop   = go;
	assign cur_phase = phase_q[idx];
	assign cur_len   = len_q[idx];
	assign cur_rcvd  = rcvd_q[idx];
	assign off_inc   = {1'b0, cur_rcvd} + 17'd1;
	assign last      = (off_inc >= {1'b0, cur_len});
	assign full_len  = {mid_entry.data, cur_len[LEN_BYTE_W-1:0]};

	always_comb begin
		nxt_phase = cur_phase;
		nxt_len   = cur_len;
		nxt_rcvd  = cur_rcvd;
		out_push  = 1'b0;
		unique case (mid_entry.op)
			OP_CLEAR: begin
				nxt_phase = PH_HUNT;
				nxt_len   = '0;
				nxt_rcvd  = '0;
			end
			OP_DATA: begin
				unique case (cur_phase)
					PH_HUNT: begin
						if (mid_entry.data == START_BYTE) begin
							nxt_phase = PH_START;
						end
					end
					PH_START: begin
						nxt_len   = {8'h00, mid_entry.data};
						nxt_phase = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						nxt_len   = full_len;
						nxt_rcvd  = '0;
						// zero length header goes straight back to hunting
						nxt_phase = (full_len != '0) ? PH_PAYLOAD : PH_HUNT;
					end
					PH_PAYLOAD: begin
						nxt_rcvd = off_inc[15:0];
						out_push = go;
						if (last) begin
							nxt_phase = PH_HUNT;
						end
					end
				endcase
			end
		endcase
	end

	always_comb begin
		out_entry.out_channel  = mid_entry.channel;
		out_entry.payload_byte = mid_entry.data;
		out_entry.byte_offset  = cur_rcvd;
		out_entry.byte_kept    = (cur_rcvd < max_q);
		out_entry.frame_last   = last;
		out_entry.frame_length = cur_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				phase_q[i] <= PH_HUNT;
				len_q[i]   <= '0;
				rcvd_q[i]  <= '0;
			end
			max_q <= MAX_STORED_RESET;
		end else begin
			if (go) begin
				phase_q[idx] <= nxt_phase;
				len_q[idx]   <= nxt_len;
				rcvd_q[idx]  <= nxt_rcvd;
			end
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
		end
	end

endmodule

FILE: src/multichannel_length_prefix_deframer.sv
// Top level of the multichannel length-prefix deframer.
// Depends on mlpd_pkg, mlpd_front, mlpd_fifo and mlpd_back.
//
// Bytes tagged with a channel number come in as beats on a queue-style port
// (push/full) and payload bytes leave on another (empty/pop). Each channel
// hunts for '<', reads a 16-bit little-endian length and then passes that many
// payload bytes out with offset, kept flag (offset below max_stored_bytes),
// last mark and declared length. A mode=1 beat returns its channel to hunting.
// One beat is accepted per cycle while full is low; a payload beat is
// registered in the middle queue, then goes through the back end into the
// result queue. The rate is set by the single per-channel state update in the
// back end, done once per cycle unless the back end stalls. Both queues are two
// beats deep, and the back end holds every beat while the result queue is full,
// so once the result side stops popping, at most four more payload beats are taken before full rises.
// max_stored_bytes should only be written while the block is idle.
module multichannel_length_prefix_deframer import mlpd_pkg::*; #(
	parameter int NUM_CHANNELS = MLPD_NUM_CHANNELS,
	parameter int MID_DEPTH    = MLPD_QUEUE_DEPTH,
	parameter int OUT_DEPTH    = MLPD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  in_item_t    item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   result,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	mid_wr_t    mid_wr;
	logic       mid_full, mid_empty, mid_pop;
	mid_entry_t mid_entry;
	logic       out_full, out_push;
	out_item_t  out_entry;

	mlpd_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
		.item     (item),
		.push     (push),
		.full     (full),
		.mid_full (mid_full),
		.mid_wr   (mid_wr)
	);

	mlpd_fifo #(.WIDTH($bits(mid_entry_t)), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (mid_wr.push),
		.wr_data (mid_wr.entry),
		.full    (mid_full),
		.pop     (mid_pop),
		.rd_data (mid_entry),
		.empty   (mid_empty)
	);

	mlpd_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mid_empty   (mid_empty),
		.mid_entry   (mid_entry),
		.mid_pop     (mid_pop),
		.out_full    (out_full),
		.out_push    (out_push),
		.out_entry   (out_entry)
	);

	mlpd_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (out_push),
		.wr_data (out_entry),
		.full    (out_full),
		.pop     (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule

FILE: src/mlpd_checker.sv
// Port-level checks for the deframer, bound to the top level.
// Depends on mlpd_pkg and multichannel_length_prefix_deframer.
module mlpd_checker import mlpd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input out_item_t   result
);

	// nothing is offered while in reset
	a_empty_in_reset: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result offered during reset");

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("stalled result beat changed");

	// offsets stay inside the declared frame
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.byte_offset < result.frame_length))
		else $error("payload offset beyond frame length");

	// the last mark sits exactly on the final byte
	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.frame_last ==
			(({1'b0, result.byte_offset} + 17'd1) == {1'b0, result.frame_length})))
		else $error("last mark not on final payload byte");

endmodule

bind multichannel_length_prefix_deframer mlpd_checker u_chk (.*);
